// File: rtl/pidl_pkg.sv
package pidl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int OPC_W        = 2;
  localparam int POS_W        = 6;
  localparam int VAL_W        = 32;
  localparam int STAT_W       = 2;
  localparam int CNT_OUT_W    = 7;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } pidl_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] result_value;
    logic [CNT_OUT_W-1:0]    entry_count;
  } pidl_rsp_t;

  typedef struct packed {
    logic ins;
    logic del;
  } pidl_ctl_t;

endpackage

// File: rtl/positional_insert_delete_list.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells,
// one entry per cell. A request (insert, delete or read) is taken on any edge
// with start high (busy stays low); every cell compares its index with the
// position and, for a valid insert or delete, shifts or loads on that same
// edge, and the result appears on out_rsp with out_valid high for exactly the
// next cycle. The receiver cannot stall, so it must take each result in
// that cycle. Errors are reported only through status; entry_count is the
// count after the operation, truncated to 7 bits.
module positional_insert_delete_list #(
  parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pidl_pkg::pidl_req_t in_req,
  output logic                out_valid,
  output pidl_pkg::pidl_rsp_t out_rsp
);
  import pidl_pkg::*;

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;
  localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

  logic [CNTW-1:0]  count_r;
  logic [CNTW-1:0]  count_nxt;
  logic             out_valid_r;
  pidl_rsp_t        out_rsp_r;
  pidl_rsp_t        rsp_nxt;
  logic             accept;
  logic [CMPW-1:0]  pos_ext;
  logic [CMPW-1:0]  cnt_ext;
  pidl_ctl_t        ctl;
  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [VAL_W-1:0] cell_tap  [CAPACITY];
  logic [VAL_W-1:0] sel_data;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_ext = CMPW'(in_req.position);
  assign cnt_ext = CMPW'(count_r);

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | cell_tap[i];
    end
  end

  always_comb begin
    ctl                  = '0;
    count_nxt            = count_r;
    rsp_nxt.status       = ST_BADPOS;
    rsp_nxt.result_value = '0;
    unique case (in_req.opcode)
      OP_INSERT: begin
        if (count_r == CAP_CNT) begin
          rsp_nxt.status = ST_FULL;
        end else if (pos_ext <= cnt_ext) begin
          ctl.ins        = accept;
          count_nxt      = count_r + CNTW'(1);
          rsp_nxt.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (pos_ext < cnt_ext) begin
          ctl.del              = accept;
          count_nxt            = count_r - CNTW'(1);
          rsp_nxt.status       = ST_DONE;
          rsp_nxt.result_value = sel_data;
        end
      end
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          rsp_nxt.status       = ST_DONE;
          rsp_nxt.result_value = sel_data;
        end
      end
      default: begin
      end
    endcase
    rsp_nxt.entry_count = CNT_OUT_W'(count_nxt);
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      pidl_cell #(
        .CMPW(CMPW),
        .IDX (g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .pos       (pos_ext),
        .ins_value (in_req.item_value),
        .left_data (cell_data[(g == 0) ? 0 : g - 1]),
        .right_data(cell_data[(g == CAPACITY - 1) ? g : g + 1]),
        .data      (cell_data[g]),
        .tap       (cell_tap[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: rtl/pidl_cell.sv
module pidl_cell #(
  parameter int CMPW = 7,
  parameter int IDX  = 0
) (
  input  logic                            clk,
  input  pidl_pkg::pidl_ctl_t             ctl,
  input  logic [CMPW-1:0]                 pos,
  input  logic [pidl_pkg::VAL_W-1:0]      ins_value,
  input  logic [pidl_pkg::VAL_W-1:0]      left_data,
  input  logic [pidl_pkg::VAL_W-1:0]      right_data,
  output logic [pidl_pkg::VAL_W-1:0]      data,
  output logic [pidl_pkg::VAL_W-1:0]      tap
);
  import pidl_pkg::*;

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic             hit;
  logic             above;

  assign hit   = (MY_IDX == pos);
  assign above = (MY_IDX > pos);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins && hit) begin
      data_nxt = ins_value;
    end else if (ctl.ins && above) begin
      data_nxt = left_data;
    end else if (ctl.del && (hit || above)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap  = hit ? data_r : '0;

endmodule
